>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pulse qualifier blocks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define SPQC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define SPQC_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> rtl/spqc_pkg.sv
// ---------------------------------------------------------------------------
// spqc_pkg
// Types and constants shared by the pulse qualifier counter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package spqc_pkg;

  localparam int TIMER_BITS = 16;
  localparam int COUNT_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int IDX_BITS   = 2;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    PH_LOW       = 2'd0,
    PH_DEBOUNCE  = 2'd1,
    PH_HIGH_WAIT = 2'd2,
    PH_HIGH      = 2'd3
  } phase_e;

  typedef enum logic [IDX_BITS-1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_HIGH_WAIT = 2'd1,
    CFG_INVERT    = 2'd2
  } cfg_idx_e;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RST  = 16'd30;
  localparam logic [CFG_BITS-1:0] HIGH_WAIT_RST = 16'd0;
  localparam logic                INVERT_RST    = 1'b1;

  typedef struct packed {
    logic [CFG_BITS-1:0] debounce;
    logic [CFG_BITS-1:0] min_high;
    logic                invert;
  } cfg_t;

  typedef struct packed {
    logic line;
    logic dir;
    logic clr;
  } item_t;

  typedef struct packed {
    logic   pulse;
    phase_e phase;
  } step_t;

  // Saturates a register value to the timer range.
  function automatic logic [TIMER_BITS-1:0] timer_load(input logic [CFG_BITS-1:0] v);
    logic [32:0] vx;
    vx = 33'(v);
    if (vx > 33'(TIMER_MAX)) begin
      return TIMER_MAX;
    end
    return TIMER_BITS'(vx);
  endfunction

endpackage

`default_nettype wire

>>> rtl/spqc_cfg_regs.sv
// ---------------------------------------------------------------------------
// spqc_cfg_regs
// Configuration registers written through the index and data port.
// ---------------------------------------------------------------------------
`default_nettype none

module spqc_cfg_regs
  import spqc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [IDX_BITS-1:0] cfg_index_i,
  input  wire logic [CFG_BITS-1:0] cfg_data_i,
  output      cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE:  cfg_d.debounce = cfg_data_i;
        CFG_HIGH_WAIT: cfg_d.min_high = cfg_data_i;
        CFG_INVERT:    cfg_d.invert   = cfg_data_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce <= DEBOUNCE_RST;
      cfg_q.min_high <= HIGH_WAIT_RST;
      cfg_q.invert   <= INVERT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/spqc_phase_fsm.sv
// ---------------------------------------------------------------------------
// spqc_phase_fsm
// Four-phase edge machine with a shared down-counting timer and pulse
// qualification on the first entry into high after low.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spqc_phase_fsm
  import spqc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  adv_i,
  input  wire logic  line_i,
  input  wire cfg_t  cfg_i,
  output      step_t step_o
);

  phase_e                phase_q, phase_d;
  logic                  last_q, last_d;
  logic                  primed_q, primed_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic [1:0]            entries_q, entries_d;

  logic level, rising, falling, expired, enter, pulse;
  logic dbnc_on, hwait_on;

  assign level    = line_i ^ cfg_i.invert;
  assign rising   = level & ~last_q;
  assign falling  = ~level & last_q;
  assign dbnc_on  = (cfg_i.debounce != '0);
  assign hwait_on = (cfg_i.min_high != '0);
  assign expired  = (timer_q <= TIMER_BITS'(1));

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (!primed_q) begin
      phase_d = level ? PH_HIGH : PH_LOW;
    end else begin
      unique case (phase_q)
        PH_LOW: begin
          if (rising) begin
            phase_d = dbnc_on ? PH_DEBOUNCE : (hwait_on ? PH_HIGH_WAIT : PH_HIGH);
          end
        end
        PH_DEBOUNCE: begin
          if (expired) begin
            phase_d = !level ? PH_LOW : (hwait_on ? PH_HIGH_WAIT : PH_HIGH);
          end
        end
        PH_HIGH_WAIT: begin
          if (falling) begin
            phase_d = dbnc_on ? PH_DEBOUNCE : PH_LOW;
          end else if (expired) begin
            phase_d = PH_HIGH;
          end
        end
        PH_HIGH: begin
          if (falling) begin
            phase_d = dbnc_on ? PH_DEBOUNCE : PH_LOW;
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // Timer, entry count and pulse.
  always_comb begin
    enter     = primed_q && (phase_d != phase_q);
    timer_d   = timer_q;
    entries_d = entries_q;
    pulse     = 1'b0;
    primed_d  = 1'b1;
    last_d    = level;
    if (primed_q && (phase_q == PH_DEBOUNCE || phase_q == PH_HIGH_WAIT)) begin
      timer_d = expired ? '0 : timer_q - TIMER_BITS'(1);
    end
    if (enter) begin
      unique case (phase_d)
        PH_DEBOUNCE:  timer_d = timer_load(cfg_i.debounce);
        PH_HIGH_WAIT: timer_d = timer_load(cfg_i.min_high);
        PH_HIGH: begin
          pulse = (entries_q == 2'd0);
          if (entries_q < 2'd2) begin
            entries_d = entries_q + 2'd1;
          end
        end
        PH_LOW:  entries_d = 2'd0;
        default: entries_d = entries_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LOW;
      last_q    <= 1'b0;
      primed_q  <= 1'b0;
      timer_q   <= '0;
      entries_q <= 2'd0;
    end else if (adv_i) begin
      phase_q   <= phase_d;
      last_q    <= last_d;
      primed_q  <= primed_d;
      timer_q   <= timer_d;
      entries_q <= entries_d;
    end
  end

  assign step_o.pulse = pulse;
  assign step_o.phase = phase_d;

  `SPQC_ASSERT(a_pulse_enters_high, clk_i, rst_ni, pulse |-> (phase_d == PH_HIGH && enter), "pulse without entry into high")
  `SPQC_ASSERT(a_first_tick_quiet, clk_i, rst_ni, !primed_q |-> !pulse, "pulse on the priming tick")
  `SPQC_NEVER(a_entries_sat, clk_i, rst_ni, entries_q == 2'd3, "entry count beyond saturation")

endmodule

`default_nettype wire

>>> rtl/spqc_pulse_counters.sv
// ---------------------------------------------------------------------------
// spqc_pulse_counters
// Saturating forward and reverse pulse counters with a clear after use.
// ---------------------------------------------------------------------------
`default_nettype none

module spqc_pulse_counters
  import spqc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  adv_i,
  input  wire logic                  pulse_i,
  input  wire logic                  dir_i,
  input  wire logic                  clr_i,
  output      logic [COUNT_BITS-1:0] fwd_o,
  output      logic [COUNT_BITS-1:0] rev_o
);

  logic [COUNT_BITS-1:0] fwd_q, fwd_d, rev_q, rev_d;
  logic [COUNT_BITS-1:0] fwd_now, rev_now;

  always_comb begin
    fwd_now = fwd_q;
    rev_now = rev_q;
    if (pulse_i) begin
      if (dir_i) begin
        if (rev_q != COUNT_MAX) begin
          rev_now = rev_q + COUNT_BITS'(1);
        end
      end else if (fwd_q != COUNT_MAX) begin
        fwd_now = fwd_q + COUNT_BITS'(1);
      end
    end
    fwd_d = clr_i ? '0 : fwd_now;
    rev_d = clr_i ? '0 : rev_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= '0;
      rev_q <= '0;
    end else if (adv_i) begin
      fwd_q <= fwd_d;
      rev_q <= rev_d;
    end
  end

  assign fwd_o = fwd_now;
  assign rev_o = rev_now;

endmodule

`default_nettype wire

>>> rtl/s0_pulse_qualifier_counter.sv
// ---------------------------------------------------------------------------
// s0_pulse_qualifier_counter
// Debounced meter pulse counter with minimum high time, one tick per item.
// ---------------------------------------------------------------------------
//  Channel  Signals                                          Flow
//  in       in_valid_i in_stall_o line/dir/clear fields      tick samples in
//  out      out_valid_o out_stall_i pulse/phase/count fields  tick results out
//  cfg      cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i   register writes
//
//  One item per cycle is sustained while out_stall_i is low; each item passes
//  through the input register and then the result register.
//  The phase machine and counters update in the cycle an item moves from the
//  input register into the result register.
//  A held result stalls the input register, and in_stall_o rises only when
//  both registers are full and out_stall_i is high.
//  Reset sets the registers to 30, 0 and 1 and clears all but data registers.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module s0_pulse_qualifier_counter
  import spqc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic                line_level_i,
  input  wire logic                dir_level_i,
  input  wire logic                clear_counts_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic                pulse_o,
  output      logic                pulse_reverse_o,
  output      logic [1:0]          phase_o,
  output      logic [15:0]         forward_count_o,
  output      logic [15:0]         reverse_count_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [IDX_BITS-1:0] cfg_index_i,
  input  wire logic [CFG_BITS-1:0] cfg_data_i
);

  cfg_t  cfg;
  step_t step;
  item_t item_q;
  logic  in_vld_q;
  logic  out_vld_q;
  logic  out_rdy, adv, in_take;
  logic  pulse_q, rev_q;
  logic [1:0]  phase_q;
  logic [15:0] fwd_q, revc_q;
  logic [COUNT_BITS-1:0] fwd, revc;

  assign out_rdy    = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_rdy;
  assign in_stall_o = in_vld_q && !out_rdy;
  assign in_take    = in_valid_i && !in_stall_o;

  spqc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.line <= line_level_i;
      item_q.dir  <= dir_level_i;
      item_q.clr  <= clear_counts_i;
    end
  end

  spqc_phase_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .line_i (item_q.line),
    .cfg_i  (cfg),
    .step_o (step)
  );

  spqc_pulse_counters u_cnt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .pulse_i (step.pulse),
    .dir_i   (item_q.dir),
    .clr_i   (item_q.clr),
    .fwd_o   (fwd),
    .rev_o   (revc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pulse_q <= step.pulse;
      rev_q   <= step.pulse & item_q.dir;
      phase_q <= step.phase;
      fwd_q   <= 16'(fwd);
      revc_q  <= 16'(revc);
    end
  end

  assign out_valid_o     = out_vld_q;
  assign pulse_o         = pulse_q;
  assign pulse_reverse_o = rev_q;
  assign phase_o         = phase_q;
  assign forward_count_o = fwd_q;
  assign reverse_count_o = revc_q;

  `SPQC_ASSERT(a_rev_needs_pulse, clk_i, rst_ni, out_vld_q && rev_q |-> pulse_q, "reverse flag without pulse")

endmodule

`default_nettype wire
